FILE: hdl/sog_pkg.sv
// Shared types and constants of the sine overlay generator.
// Used by sog_ctrl, sog_dpath and the top level; depends on nothing.
`timescale 1ns / 1ps

package sog_pkg;

   // Input command codes.
   localparam logic [1:0] CMD_START   = 2'd0;
   localparam logic [1:0] CMD_MONITOR = 2'd1;
   localparam logic [1:0] CMD_TICK    = 2'd2;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_AMPLITUDE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_WEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP    = 2'd2;

   // Field and register widths.
   localparam int CSR_W    = 32;
   localparam int AMP_W    = 31;
   localparam int WEIGHT_W = 16;
   localparam int STEP_W   = 32;
   localparam int POS_W    = 32;
   localparam int ANGLE_W  = 19;

   // Datapath widths.
   localparam int MUL_W  = 33;          // signed operand width of the shared multiplier
   localparam int PROD_W = 2 * MUL_W;   // full product
   localparam int ACC_W  = 50;          // smoothing sums stay below 2^48 in magnitude
   localparam int POLY_W = 31;          // Q2.30 polynomial values, never above 2^31
   localparam int TRIG_W = 18;          // signed Q1.16 sine, within +-65536
   localparam int FRAC_W = 16;
   localparam int Q30    = 30;

   localparam logic [POLY_W-1:0] ONE_Q30   = POLY_W'(1) << Q30;
   localparam logic [16:0]       TRIG_MAX  = 17'd65536;
   localparam logic [17:0]       WEIGHT_ONE = 18'd65536;
   localparam logic [ACC_W-1:0]  ROUND_HALF = ACC_W'(32768);
   localparam logic [32:0]       TRIG_ROUND = 33'd8192;

   // Quarter-wave sine polynomial, highest-order coefficient first.
   localparam logic [POLY_W-1:0] POLY_E = 31'd172272;
   localparam logic [1:0]        HORNER_LAST = 2'd3;

   function automatic logic [POLY_W-1:0] poly_coef(input logic [1:0] idx);
      logic [POLY_W-1:0] c;
      unique case (idx)
         2'd0: c = 31'd5026997;
         2'd1: c = 31'd85569306;
         2'd2: c = 31'd693598667;
         2'd3: c = 31'd1686629713;
      endcase
      return c;
   endfunction

   // Redundancy angle sweep in millidegrees.
   localparam logic signed [ANGLE_W-1:0] SWEEP_LIMIT     = 19'sd45000;
   localparam logic signed [ANGLE_W-1:0] SWEEP_LIMIT_NEG = -19'sd45000;
   localparam logic signed [ANGLE_W-1:0] SWEEP_STEP      = 19'sd100;

   // Datapath operation codes, one issued per cycle by the controller.
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
   localparam logic [OP_W-1:0] OP_SETUP   = 4'd1;
   localparam logic [OP_W-1:0] OP_MUL_TT  = 4'd2;
   localparam logic [OP_W-1:0] OP_T2      = 4'd3;
   localparam logic [OP_W-1:0] OP_MUL_PT2 = 4'd4;
   localparam logic [OP_W-1:0] OP_HORNER  = 4'd5;
   localparam logic [OP_W-1:0] OP_MUL_PT  = 4'd6;
   localparam logic [OP_W-1:0] OP_TRIG    = 4'd7;
   localparam logic [OP_W-1:0] OP_MUL_AMP = 4'd8;
   localparam logic [OP_W-1:0] OP_FRESH   = 4'd9;
   localparam logic [OP_W-1:0] OP_MUL_OLD = 4'd10;
   localparam logic [OP_W-1:0] OP_KEEP    = 4'd11;
   localparam logic [OP_W-1:0] OP_MUL_NEW = 4'd12;
   localparam logic [OP_W-1:0] OP_SUM     = 4'd13;
   localparam logic [OP_W-1:0] OP_OFFSET  = 4'd14;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            sel;       // 0 works on the sine channel, 1 on the cosine channel
      logic [1:0]      coef;      // Horner coefficient index
      logic            start;     // start item accepted
      logic            monitor;   // monitor item accepted
      logic            tick;      // tick item accepted
      logic            load_out;  // result register takes the finished tick
   } sog_cmd_type;

endpackage

FILE: hdl/sine_overlay_generator_with_sweep.sv
// Top level of the sine overlay generator: configuration registers and the
// controller and datapath instances. Depends on sog_pkg, sog_ctrl and sog_dpath.
`timescale 1ns / 1ps

// Sine overlay generator with redundancy-angle sweep. Each tick item advances
// a phase accumulator, evaluates the sine and cosine of the current phase with
// a quarter-wave polynomial, scales them by the amplitude, runs both through a
// first-order exponential smoother and adds the smoothed offsets to the pose
// with saturation; the commanded redundancy angle moves 0.1 degree per tick in
// a triangle between -45 and +45 degrees. A start item clears phase and
// offsets, a monitor item loads the measured angle; neither returns a result.
// Timing: a tick item holds the input from its accept cycle through the sine
// channel, the cosine channel and the load of the result register, a sequence
// set by the single shared 33x33 multiplier that is used nine times per channel.
// Start, monitor and unused commands leave the controller idle and stall nothing.
// The result register lets the next item be accepted while a result still
// waits on rsp_stall; a tick only finishes once that register is free.
// SINE_TABLE_DEPTH must be a power of two.

module sine_overlay_generator_with_sweep #(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int PHASE_BITS       = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Input channel.
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_cmd,
   input  logic signed [sog_pkg::POS_W-1:0]       req_pose_x,
   input  logic signed [sog_pkg::POS_W-1:0]       req_pose_y,
   input  logic signed [sog_pkg::ANGLE_W-1:0]     req_measured_angle,
   // Result channel.
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [sog_pkg::POS_W-1:0]       rsp_out_x,
   output logic signed [sog_pkg::POS_W-1:0]       rsp_out_y,
   output logic signed [sog_pkg::ANGLE_W-1:0]     rsp_out_angle,
   // Configuration write port.
   input  logic                                   csr_we,
   input  logic [sog_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [sog_pkg::CSR_W-1:0]              csr_wdata
);

   // Configuration registers. Writes to an unused index are ignored. The user must
   // write the port only while the block is idle; the block does not enforce it.
   logic [sog_pkg::AMP_W-1:0]    amplitude_ff, amplitude_in;
   logic [sog_pkg::WEIGHT_W-1:0] filter_weight_ff, filter_weight_in;
   logic [sog_pkg::STEP_W-1:0]   phase_step_ff, phase_step_in;

   sog_pkg::sog_cmd_type cmd;

   always_comb begin
      amplitude_in     = amplitude_ff;
      filter_weight_in = filter_weight_ff;
      phase_step_in    = phase_step_ff;
      if (csr_we) begin
         unique case (csr_index)
            sog_pkg::CSR_AMPLITUDE:     amplitude_in     = csr_wdata[sog_pkg::AMP_W-1:0];
            sog_pkg::CSR_FILTER_WEIGHT: filter_weight_in = csr_wdata[sog_pkg::WEIGHT_W-1:0];
            sog_pkg::CSR_PHASE_STEP:    phase_step_in    = csr_wdata[sog_pkg::STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amplitude_ff     <= '0;
         filter_weight_ff <= '0;
         phase_step_ff    <= '0;
      end else begin
         amplitude_ff     <= amplitude_in;
         filter_weight_ff <= filter_weight_in;
         phase_step_ff    <= phase_step_in;
      end
   end

   // The controller owns both handshakes and steps the datapath one
   // operation per cycle through each tick.
   sog_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   sog_dpath #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .PHASE_BITS       (PHASE_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .amplitude          (amplitude_ff),
      .filter_weight      (filter_weight_ff),
      .phase_step         (phase_step_ff),
      .req_pose_x         (req_pose_x),
      .req_pose_y         (req_pose_y),
      .req_measured_angle (req_measured_angle),
      .rsp_out_x          (rsp_out_x),
      .rsp_out_y          (rsp_out_y),
      .rsp_out_angle      (rsp_out_angle)
   );

endmodule

FILE: hdl/sog_ctrl.sv
// Controller of the sine overlay generator: handshakes and operation sequencing.
// Depends on sog_pkg.
`timescale 1ns / 1ps

module sog_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_cmd,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sog_pkg::sog_cmd_type   cmd
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_SETUP   = 4'd1;
   localparam logic [3:0] ST_MUL_TT  = 4'd2;
   localparam logic [3:0] ST_T2      = 4'd3;
   localparam logic [3:0] ST_MUL_PT2 = 4'd4;
   localparam logic [3:0] ST_HORNER  = 4'd5;
   localparam logic [3:0] ST_MUL_PT  = 4'd6;
   localparam logic [3:0] ST_TRIG    = 4'd7;
   localparam logic [3:0] ST_MUL_AMP = 4'd8;
   localparam logic [3:0] ST_FRESH   = 4'd9;
   localparam logic [3:0] ST_MUL_OLD = 4'd10;
   localparam logic [3:0] ST_KEEP    = 4'd11;
   localparam logic [3:0] ST_MUL_NEW = 4'd12;
   localparam logic [3:0] ST_SUM     = 4'd13;
   localparam logic [3:0] ST_OFFSET  = 4'd14;
   localparam logic [3:0] ST_DONE    = 4'd15;

   logic [3:0] state_ff, state_in;
   logic       sel_ff, sel_in;
   logic [1:0] coef_ff, coef_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       load;

   assign accept = req_valid && (state_ff == ST_IDLE);
   assign load   = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      coef_in  = coef_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == sog_pkg::CMD_TICK)) begin
               state_in = ST_SETUP;
               sel_in   = 1'b0;
            end
         end
         ST_SETUP:   state_in = ST_MUL_TT;
         ST_MUL_TT:  state_in = ST_T2;
         ST_T2: begin
            coef_in  = 2'd0;
            state_in = ST_MUL_PT2;
         end
         ST_MUL_PT2: state_in = ST_HORNER;
         ST_HORNER: begin
            if (coef_ff == sog_pkg::HORNER_LAST) begin
               state_in = ST_MUL_PT;
            end else begin
               coef_in  = coef_ff + 2'd1;
               state_in = ST_MUL_PT2;
            end
         end
         ST_MUL_PT:  state_in = ST_TRIG;
         ST_TRIG:    state_in = ST_MUL_AMP;
         ST_MUL_AMP: state_in = ST_FRESH;
         ST_FRESH:   state_in = ST_MUL_OLD;
         ST_MUL_OLD: state_in = ST_KEEP;
         ST_KEEP:    state_in = ST_MUL_NEW;
         ST_MUL_NEW: state_in = ST_SUM;
         ST_SUM:     state_in = ST_OFFSET;
         ST_OFFSET: begin
            if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = ST_SETUP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_comb begin
      cmd.sel      = sel_ff;
      cmd.coef     = coef_ff;
      cmd.start    = accept && (req_cmd == sog_pkg::CMD_START);
      cmd.monitor  = accept && (req_cmd == sog_pkg::CMD_MONITOR);
      cmd.tick     = accept && (req_cmd == sog_pkg::CMD_TICK);
      cmd.load_out = load;
      unique case (state_ff)
         ST_SETUP:   cmd.op = sog_pkg::OP_SETUP;
         ST_MUL_TT:  cmd.op = sog_pkg::OP_MUL_TT;
         ST_T2:      cmd.op = sog_pkg::OP_T2;
         ST_MUL_PT2: cmd.op = sog_pkg::OP_MUL_PT2;
         ST_HORNER:  cmd.op = sog_pkg::OP_HORNER;
         ST_MUL_PT:  cmd.op = sog_pkg::OP_MUL_PT;
         ST_TRIG:    cmd.op = sog_pkg::OP_TRIG;
         ST_MUL_AMP: cmd.op = sog_pkg::OP_MUL_AMP;
         ST_FRESH:   cmd.op = sog_pkg::OP_FRESH;
         ST_MUL_OLD: cmd.op = sog_pkg::OP_MUL_OLD;
         ST_KEEP:    cmd.op = sog_pkg::OP_KEEP;
         ST_MUL_NEW: cmd.op = sog_pkg::OP_MUL_NEW;
         ST_SUM:     cmd.op = sog_pkg::OP_SUM;
         ST_OFFSET:  cmd.op = sog_pkg::OP_OFFSET;
         default:    cmd.op = sog_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= 1'b0;
         coef_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         coef_ff      <= coef_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hdl/sog_dpath.sv
// Datapath of the sine overlay generator: phase, sine polynomial, smoothing,
// sweep and the result register around one shared multiplier. Depends on sog_pkg.
`timescale 1ns / 1ps

module sog_dpath #(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int PHASE_BITS       = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sog_pkg::sog_cmd_type                 cmd,
   input  logic [sog_pkg::AMP_W-1:0]            amplitude,
   input  logic [sog_pkg::WEIGHT_W-1:0]         filter_weight,
   input  logic [sog_pkg::STEP_W-1:0]           phase_step,
   input  logic signed [sog_pkg::POS_W-1:0]     req_pose_x,
   input  logic signed [sog_pkg::POS_W-1:0]     req_pose_y,
   input  logic signed [sog_pkg::ANGLE_W-1:0]   req_measured_angle,
   output logic signed [sog_pkg::POS_W-1:0]     rsp_out_x,
   output logic signed [sog_pkg::POS_W-1:0]     rsp_out_y,
   output logic signed [sog_pkg::ANGLE_W-1:0]   rsp_out_angle
);

   localparam int TBL_BITS = $clog2(SINE_TABLE_DEPTH);
   localparam int MUL_W    = sog_pkg::MUL_W;
   localparam int ACC_W    = sog_pkg::ACC_W;
   localparam int POLY_W   = sog_pkg::POLY_W;
   localparam int POS_W    = sog_pkg::POS_W;
   localparam int ANGLE_W  = sog_pkg::ANGLE_W;
   localparam int Q30_LO   = sog_pkg::Q30;
   localparam int Q_HI     = sog_pkg::Q30 + 31;

   // Architectural state.
   logic [PHASE_BITS-1:0]      phase_ff, phase_in;
   logic signed [POS_W-1:0]    offset_sin_ff, offset_sin_in;
   logic signed [POS_W-1:0]    offset_cos_ff, offset_cos_in;
   logic signed [ANGLE_W-1:0]  sweep_angle_ff, sweep_angle_in;
   logic                       sweep_rising_ff, sweep_rising_in;

   // Working registers of one tick.
   logic [TBL_BITS-1:0]        k_ff;
   logic signed [POS_W-1:0]    pose_x_ff, pose_y_ff;
   logic [POLY_W-1:0]          t_ff, t2_ff, p_ff;
   logic                       neg_ff;
   logic signed [sog_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [sog_pkg::TRIG_W-1:0] trig_ff, trig_in;
   logic signed [MUL_W-1:0]    fresh_ff;
   logic signed [ACC_W-1:0]    acc_ff;

   // Result register.
   logic signed [POS_W-1:0]    out_x_ff, out_y_ff;
   logic signed [ANGLE_W-1:0]  out_angle_ff;

   logic signed [MUL_W-1:0]    mul_a, mul_b;
   logic                       mul_en;
   logic [1:0]                 quad;
   logic [POLY_W-1:0]          t_raw;
   logic [31:0]                s_hi;
   logic [32:0]                s_rnd;
   logic [18:0]                s_q;
   logic [16:0]                s_clamp;
   logic signed [ACC_W-1:0]    fresh_rnd, offset_rnd;
   logic signed [POS_W-1:0]    old_offset;
   logic [17:0]                weight_rest;

   function automatic logic signed [POS_W-1:0] sat_add(
      input logic signed [POS_W-1:0] a,
      input logic signed [POS_W-1:0] b
   );
      logic signed [POS_W:0] s;
      logic signed [POS_W-1:0] r;
      s = {a[POS_W-1], a} + {b[POS_W-1], b};
      if (s[POS_W] != s[POS_W-1]) begin
         r = s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
         r = s[POS_W-1:0];
      end
      return r;
   endfunction

   // Quadrant and position within the quarter wave.
   assign quad  = k_ff[TBL_BITS-1 -: 2] + {1'b0, cmd.sel};
   assign t_raw = POLY_W'(k_ff[TBL_BITS-3:0]) << (32 - TBL_BITS);

   assign old_offset  = cmd.sel ? offset_cos_ff : offset_sin_ff;
   assign weight_rest = sog_pkg::WEIGHT_ONE - {2'b00, filter_weight};

   // Operand selection of the shared multiplier.
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      unique case (cmd.op)
         sog_pkg::OP_MUL_TT: begin
            mul_a = {2'b00, t_ff};
            mul_b = {2'b00, t_ff};
         end
         sog_pkg::OP_MUL_PT2: begin
            mul_a = {2'b00, p_ff};
            mul_b = {2'b00, t2_ff};
         end
         sog_pkg::OP_MUL_PT: begin
            mul_a = {2'b00, p_ff};
            mul_b = {2'b00, t_ff};
         end
         sog_pkg::OP_MUL_AMP: begin
            mul_a = {2'b00, amplitude};
            mul_b = MUL_W'(trig_ff);
         end
         sog_pkg::OP_MUL_OLD: begin
            mul_a = {old_offset[POS_W-1], old_offset};
            mul_b = {{(MUL_W-sog_pkg::WEIGHT_W){1'b0}}, filter_weight};
         end
         sog_pkg::OP_MUL_NEW: begin
            mul_a = fresh_ff;
            mul_b = {{(MUL_W-18){1'b0}}, weight_rest};
         end
         default: mul_en = 1'b0;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Final polynomial product to rounded, clamped, signed Q1.16.
   assign s_hi    = prod_ff[Q_HI:Q30_LO];
   assign s_rnd   = {1'b0, s_hi} + sog_pkg::TRIG_ROUND;
   assign s_q     = s_rnd[32:14];
   assign s_clamp = (s_q > {2'b00, sog_pkg::TRIG_MAX}) ? sog_pkg::TRIG_MAX : s_q[16:0];
   assign trig_in = neg_ff ? -$signed({1'b0, s_clamp}) : $signed({1'b0, s_clamp});

   assign fresh_rnd  = prod_ff[ACC_W-1:0] + sog_pkg::ROUND_HALF;
   assign offset_rnd = acc_ff + sog_pkg::ROUND_HALF;

   // State updates taken at item acceptance and at the end of each channel.
   always_comb begin
      phase_in        = phase_ff;
      offset_sin_in   = offset_sin_ff;
      offset_cos_in   = offset_cos_ff;
      sweep_angle_in  = sweep_angle_ff;
      sweep_rising_in = sweep_rising_ff;
      if (cmd.start) begin
         phase_in      = '0;
         offset_sin_in = '0;
         offset_cos_in = '0;
      end
      if (cmd.monitor) begin
         sweep_angle_in = req_measured_angle;
      end
      if (cmd.tick) begin
         phase_in = phase_ff + phase_step[PHASE_BITS-1:0];
         if (sweep_rising_ff) begin
            if (sweep_angle_ff < sog_pkg::SWEEP_LIMIT) begin
               sweep_angle_in = sweep_angle_ff + sog_pkg::SWEEP_STEP;
            end else begin
               sweep_rising_in = 1'b0;
            end
         end else begin
            if (sweep_angle_ff > sog_pkg::SWEEP_LIMIT_NEG) begin
               sweep_angle_in = sweep_angle_ff - sog_pkg::SWEEP_STEP;
            end else begin
               sweep_rising_in = 1'b1;
            end
         end
      end
      if (cmd.op == sog_pkg::OP_OFFSET) begin
         if (cmd.sel) begin
            offset_cos_in = offset_rnd[sog_pkg::FRAC_W +: POS_W];
         end else begin
            offset_sin_in = offset_rnd[sog_pkg::FRAC_W +: POS_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= '0;
         offset_sin_ff   <= '0;
         offset_cos_ff   <= '0;
         sweep_angle_ff  <= '0;
         sweep_rising_ff <= 1'b1;
      end else begin
         phase_ff        <= phase_in;
         offset_sin_ff   <= offset_sin_in;
         offset_cos_ff   <= offset_cos_in;
         sweep_angle_ff  <= sweep_angle_in;
         sweep_rising_ff <= sweep_rising_in;
      end
   end

   // Working and result registers carry payload only.
   always_ff @(posedge clock) begin
      if (cmd.tick) begin
         k_ff      <= phase_ff[PHASE_BITS-1 -: TBL_BITS];
         pose_x_ff <= req_pose_x;
         pose_y_ff <= req_pose_y;
      end
      if (mul_en) begin
         prod_ff <= prod_in;
      end
      unique case (cmd.op)
         sog_pkg::OP_SETUP: begin
            t_ff   <= quad[0] ? (sog_pkg::ONE_Q30 - t_raw) : t_raw;
            neg_ff <= quad[1];
         end
         sog_pkg::OP_T2: begin
            t2_ff <= prod_ff[Q30_LO +: POLY_W];
            p_ff  <= sog_pkg::POLY_E;
         end
         sog_pkg::OP_HORNER: p_ff    <= sog_pkg::poly_coef(cmd.coef) - prod_ff[Q30_LO +: POLY_W];
         sog_pkg::OP_TRIG:   trig_ff <= trig_in;
         sog_pkg::OP_FRESH:  fresh_ff <= fresh_rnd[sog_pkg::FRAC_W +: MUL_W];
         sog_pkg::OP_KEEP:   acc_ff  <= prod_ff[ACC_W-1:0];
         sog_pkg::OP_SUM:    acc_ff  <= acc_ff + prod_ff[ACC_W-1:0];
         default: begin
         end
      endcase
      if (cmd.load_out) begin
         out_x_ff     <= sat_add(pose_x_ff, offset_sin_ff);
         out_y_ff     <= sat_add(pose_y_ff, offset_cos_ff);
         out_angle_ff <= sweep_angle_ff;
      end
   end

   assign rsp_out_x     = out_x_ff;
   assign rsp_out_y     = out_y_ff;
   assign rsp_out_angle = out_angle_ff;

endmodule
